@@ rtl/core/bpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

   localparam int DEF_PAGE_COUNT     = 4096;
   localparam int DEF_PAGE_BYTES     = 4096;
   localparam int DEF_RESERVED_PAGES = 256;

   localparam int MAP_WORD_BITS = 8;
   localparam int WSEL_W        = $clog2(MAP_WORD_BITS);

   localparam int SIZE_W     = 25;
   localparam int ADDR_W     = 24;
   localparam int STAT_W     = 2;
   localparam int CNT_OUT_W  = 13;
   localparam int DIV_W      = 26;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_OOM  = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/bpa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/bpa_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpa_div #(
   parameter int DIVISOR = bpa_pkg::DEF_PAGE_BYTES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bpa_pkg::div_req_type div_req,
   output bpa_pkg::div_rsp_type      div_rsp
);
   import bpa_pkg::*;

   // reciprocal multiply, exact for every DIV_W-bit dividend
   localparam int SHIFT  = DIV_W + $clog2(DIVISOR);
   localparam int MUL_W  = DIV_W + 1;
   localparam int PROD_W = DIV_W + MUL_W;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

   logic              valid_ff, valid_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(num_ff) * PROD_W'(RECIP);

   always_comb begin
      valid_in = div_req.start;
      done_in  = valid_ff;
      num_in   = div_req.start ? div_req.dividend : num_ff;
      quo_in   = valid_ff ? DIV_W'(prod >> SHIFT) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Allocate: page-count multiply, then a scan of the 8-page map words,
//   then a read and a write per map word marked, then the result.
// Free: page-number multiply, then a read and a write per map word visited, then the result.
// One request at a time; the map memory's read-modify-write sets the pace.
// After reset the map is swept one word a cycle with req_tready low.
module bitmap_page_allocator #(
   parameter int PAGE_COUNT     = bpa_pkg::DEF_PAGE_COUNT,
   parameter int PAGE_BYTES     = bpa_pkg::DEF_PAGE_BYTES,
   parameter int RESERVED_PAGES = bpa_pkg::DEF_RESERVED_PAGES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // size_bytes[24:0], release_address[48:25], zero pad
   input  wire logic [bpa_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[0]
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // start_address[23:0], status[25:24], pages_freed[38:26], pages_in_use[51:39], zero pad
   output logic      [bpa_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bpa_pkg::*;

   localparam int WORD_COUNT = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PG_W       = WADDR_W + WSEL_W;
   localparam int CNT_W      = $clog2(PAGE_COUNT + 1);
   localparam int RES_CLAMP  = (RESERVED_PAGES > PAGE_COUNT) ? PAGE_COUNT : RESERVED_PAGES;
   localparam int PROD_W     = PG_W + ADDR_W;
   localparam int CMP_W      = CNT_W + WSEL_W;
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);

   state_type state_ff, state_in;

   logic                     op_ff, op_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic [PG_W-1:0]          start_page_ff, start_page_in;
   logic [PG_W-1:0]          cur_page_ff, cur_page_in;
   logic [CNT_W-1:0]         freed_ff, freed_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         need_ff, need_in;
   logic [CNT_W-1:0]         run_ff, run_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [WADDR_W-1:0]       word_ff, word_in;
   logic [WADDR_W-1:0]       data_word_ff, data_word_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en, ram_rd_en;
   logic [WADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
   logic [MAP_WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic                     accept;
   logic                     rsp_load;
   logic [SIZE_W-1:0]        req_size;
   logic [ADDR_W-1:0]        req_addr;
   logic                     div_oom;
   logic                     div_beyond;

   logic [WADDR_W-1:0]       cur_word;
   logic [WSEL_W-1:0]        cur_off;
   logic [MAP_WORD_BITS-1:0] init_word;
   logic [CNT_W-1:0]         scan_run;
   logic                     scan_hit;
   logic [PG_W-1:0]          scan_start;
   logic [MAP_WORD_BITS-1:0] mark_sel;
   logic [CNT_W-1:0]         mark_taken;
   logic [MAP_WORD_BITS-1:0] free_clr;
   logic                     free_active;
   logic [CNT_W-1:0]         freed_sum;
   logic [PROD_W-1:0]        start_prod;
   logic [ADDR_W-1:0]        rsp_addr;
   logic [CNT_W+CNT_OUT_W-1:0] freed_ext;
   logic [CNT_W+CNT_OUT_W-1:0] count_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_size   = req_tdata[SIZE_W-1:0];
   assign req_addr   = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_tready);
   assign div_oom    = (div_rsp.quotient > DIV_W'(PAGE_COUNT));
   assign div_beyond = (div_rsp.quotient >= DIV_W'(PAGE_COUNT));
   assign cur_word   = cur_page_ff[PG_W-1:WSEL_W];
   assign cur_off    = cur_page_ff[WSEL_W-1:0];

   bpa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (WORD_COUNT),
      .AW    (WADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bpa_div #(
      .DIVISOR (PAGE_BYTES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         init_word[b] = (int'({word_ff, WSEL_W'(b)}) < RES_CLAMP);
      end
   end

   // first fit over one map word; pages past the map count as used
   always_comb begin
      logic [CNT_W-1:0] run;
      logic             hit;
      logic [PG_W-1:0]  hit_page;
      logic [PG_W-1:0]  pg;
      run      = run_ff;
      hit      = 1'b0;
      hit_page = '0;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         pg = {data_word_ff, WSEL_W'(b)};
         if (!hit) begin
            if (ram_rd_data[b] || (int'(pg) >= PAGE_COUNT)) begin
               run = '0;
            end else begin
               run = run + 1'b1;
               if (run == need_ff) begin
                  hit      = 1'b1;
                  hit_page = pg;
               end
            end
         end
      end
      scan_run   = run;
      scan_hit   = hit;
      scan_start = PG_W'((PG_W + 1)'(hit_page) + 1 - (PG_W + 1)'(need_ff));
   end

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         mark_sel[b] = (WSEL_W'(b) >= cur_off) &&
                       (CMP_W'(WSEL_W'(b) - cur_off) < CMP_W'(rem_ff));
      end
      mark_taken = CNT_W'($countones(mark_sel));
   end

   always_comb begin
      logic active;
      active   = 1'b1;
      free_clr = '0;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         if (WSEL_W'(b) >= cur_off) begin
            if (active && ram_rd_data[b]) begin
               free_clr[b] = 1'b1;
            end else begin
               active = 1'b0;
            end
         end
      end
      free_active = active;
      freed_sum   = freed_ff + CNT_W'($countones(free_clr));
   end

   assign start_prod = PROD_W'(start_page_ff) * PROD_W'(PAGE_BYTES);
   assign rsp_addr   = (op_ff == OP_ALLOC && status_ff == STATUS_OK) ?
                       start_prod[ADDR_W-1:0] : '0;
   assign freed_ext  = (CNT_W + CNT_OUT_W)'(freed_ff);
   assign count_ext  = (CNT_W + CNT_OUT_W)'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (word_ff == LAST_WORD) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_ALLOC && req_size == '0) state_in = ST_RESULT;
               else state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (op_ff == OP_ALLOC) state_in = div_oom ? ST_RESULT : ST_SCAN;
               else state_in = div_beyond ? ST_RESULT : ST_FREE_RD;
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff) begin
               if (scan_hit) state_in = ST_MARK_RD;
               else if (data_word_ff == LAST_WORD) state_in = ST_RESULT;
            end
         end
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: begin
            if (rem_ff == mark_taken) state_in = ST_RESULT;
            else state_in = ST_MARK_RD;
         end
         ST_FREE_RD: state_in = ST_FREE_WR;
         ST_FREE_WR: begin
            if (free_active && cur_word != LAST_WORD) state_in = ST_FREE_RD;
            else state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in            = op_ff;
      status_in        = status_ff;
      start_page_in    = start_page_ff;
      cur_page_in      = cur_page_ff;
      freed_in         = freed_ff;
      count_in         = count_ff;
      need_in          = need_ff;
      run_in           = run_ff;
      rem_in           = rem_ff;
      word_in          = word_ff;
      data_word_in     = data_word_ff;
      rd_valid_in      = 1'b0;
      rsp_data_in      = rsp_data_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = cur_word;
      ram_wr_data      = '0;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = cur_word;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(req_addr);
      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = word_ff;
            ram_wr_data = init_word;
            if (word_ff != LAST_WORD) word_in = word_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               freed_in  = '0;
               status_in = STATUS_OK;
               if (req_tuser == OP_ALLOC) begin
                  div_req.dividend = DIV_W'(req_size) + DIV_W'(PAGE_BYTES - 1);
               end
               if (req_tuser == OP_ALLOC && req_size == '0) begin
                  status_in = STATUS_ZERO;
               end else begin
                  div_req.start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (op_ff == OP_ALLOC) begin
                  if (div_oom) begin
                     status_in = STATUS_OOM;
                  end else begin
                     need_in = div_rsp.quotient[CNT_W-1:0];
                     word_in = '0;
                     run_in  = '0;
                  end
               end else begin
                  cur_page_in = div_rsp.quotient[PG_W-1:0];
               end
            end
         end
         ST_SCAN: begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = word_ff;
            rd_valid_in  = 1'b1;
            data_word_in = word_ff;
            if (word_ff != LAST_WORD) word_in = word_ff + 1'b1;
            if (rd_valid_ff) begin
               run_in = scan_run;
               if (scan_hit) begin
                  start_page_in = scan_start;
                  cur_page_in   = scan_start;
                  rem_in        = need_ff;
               end else if (data_word_ff == LAST_WORD) begin
                  status_in = STATUS_OOM;
               end
            end
         end
         ST_MARK_RD: begin
            ram_rd_en = 1'b1;
         end
         ST_MARK_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data | mark_sel;
            rem_in      = rem_ff - mark_taken;
            cur_page_in = {cur_word + 1'b1, WSEL_W'(0)};
            if (rem_ff == mark_taken) count_in = count_ff + need_ff;
         end
         ST_FREE_RD: begin
            ram_rd_en = 1'b1;
         end
         ST_FREE_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data & ~free_clr;
            freed_in    = freed_sum;
            cur_page_in = {cur_word + 1'b1, WSEL_W'(0)};
            if (!(free_active && cur_word != LAST_WORD)) count_in = count_ff - freed_sum;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_data_in = RSP_DATA_W'({count_ext[CNT_OUT_W-1:0], freed_ext[CNT_OUT_W-1:0],
                                          status_ff, rsp_addr});
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         word_ff      <= '0;
         count_ff     <= CNT_W'(RES_CLAMP);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      start_page_ff <= start_page_in;
      cur_page_ff   <= cur_page_in;
      freed_ff      <= freed_in;
      need_ff       <= need_in;
      run_ff        <= run_in;
      rem_ff        <= rem_in;
      data_word_ff  <= data_word_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25:24] == STATUS_OK || rsp_tdata[25:24] == STATUS_ZERO ||
                      rsp_tdata[25:24] == STATUS_OOM))
      else $error("bad status code");
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25:24] != STATUS_OK) |->
         (rsp_tdata[23:0] == '0 && rsp_tdata[38:26] == '0))
      else $error("error result carries address or freed count");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PAGE_COUNT))
      else $error("used page count above page count");
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_INIT || state_ff == ST_MARK_WR || state_ff == ST_FREE_WR))
      else $error("map write outside a write state");
   a_mark_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_RD) |-> (rem_ff != '0))
      else $error("mark pass with nothing left to mark");
`endif

endmodule
`default_nettype wire
